/* rtl/min_heap_priority_queue_assert.svh */
// ---------------------------------------------------------------------------
// min_heap_priority_queue_assert
// assertion macros for the heap queue, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MHPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MHPQ_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHPQ_ASSERT(label, clk, rst_n, prop, msg)
`define MHPQ_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/mhpq_pkg.sv */
// ---------------------------------------------------------------------------
// mhpq_pkg
// shared types and constants of the min-heap priority queue
// ---------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DefCapacity   = 1024;
    localparam int DefValueWidth = 32;
    localparam int TagWidth      = 24;
    localparam int InValueWidth  = 32;
    localparam int CountOutWidth = 11;

    localparam logic [1:0] ModePush     = 2'd0;
    localparam logic [1:0] ModeExtract  = 2'd1;
    localparam logic [1:0] ModeDecrease = 2'd2;

    localparam logic [2:0] StDone     = 3'd0;
    localparam logic [2:0] StExtract  = 3'd1;
    localparam logic [2:0] StEmpty    = 3'd2;
    localparam logic [2:0] StFull     = 3'd3;
    localparam logic [2:0] StNotFound = 3'd4;

    // datapath address select for the memory read port
    typedef enum logic [2:0] {
        RdPos   = 3'd0,
        RdPar   = 3'd1,
        RdLeft  = 3'd2,
        RdRight = 3'd3,
        RdScan  = 3'd4,
        RdLast  = 3'd5
    } rd_sel_t;

    typedef struct packed {
        logic    load_item;   // latch input beat, init position
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_a;       // capture read data into slot a
        logic    cap_b;       // capture read data into slot b
        logic    cap_c;       // capture read data into slot c
        logic    wr_new_last; // write new item at count+1, pos <= count+1
        logic    wr_a_at_pos; // write slot a entry at pos
        logic    wr_b_at_pos; // write slot b at pos
        logic    wr_b_at_par; // write slot b at parent
        logic    wr_a_at_best;
        logic    wr_val_at_pos; // write input value over slot a at pos
        logic    pos_to_par;
        logic    pos_to_best;
        logic    pos_to_scan;
        logic    save_min;    // save slot a value as result
        logic    cnt_inc;
        logic    cnt_dec;
        logic    scan_init;
        logic    scan_inc;
        logic    a_from_in;   // replace slot a value with input value
        logic    set_best_left;
        logic    set_best_right;
        logic    b_from_c;
        logic    out_load;
        logic [2:0] out_status;
    } mhpq_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       empty;
        logic       pos_is_root;
        logic       a_lt_b;      // slot a < slot b
        logic       b_lt_a;      // slot b < slot a
        logic       c_lt_b;      // slot c < slot b
        logic       left_ok;     // left child within count
        logic       right_ok;
        logic       scan_done;   // scan index past count
        logic       tag_hit;     // slot a tag equals target
        logic       out_busy;
    } mhpq_sts_t;

endpackage

/* rtl/mhpq_datapath.sv */
// ---------------------------------------------------------------------------
// mhpq_datapath
// heap memory, working registers, position and count registers
// ---------------------------------------------------------------------------
module mhpq_datapath #(
    parameter int CAPACITY    = mhpq_pkg::DefCapacity,
    parameter int VALUE_WIDTH = mhpq_pkg::DefValueWidth
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mhpq_pkg::mhpq_cmd_t                     cmd,
    output mhpq_pkg::mhpq_sts_t                     sts,
    input  logic [1:0]                              mode,
    input  logic signed [mhpq_pkg::InValueWidth-1:0] value,
    input  logic [mhpq_pkg::TagWidth-1:0]           target_tag,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output logic [2:0]                              status,
    output logic signed [mhpq_pkg::InValueWidth-1:0] min_value,
    output logic [mhpq_pkg::CountOutWidth-1:0]      entry_count
);
    localparam int CW = $clog2(CAPACITY + 2);   // positions 0 .. capacity+1
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = VALUE_WIDTH + mhpq_pkg::TagWidth;
    localparam int TW = mhpq_pkg::TagWidth;

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rd_data;

    logic [1:0]             mode_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [TW-1:0]          tag_reg;
    logic [TW-1:0]          op_reg;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          pos_reg;
    logic [CW-1:0]          best_reg;
    logic [CW-1:0]          scan_reg;
    logic [EW-1:0]          a_reg, b_reg, c_reg;
    logic [VALUE_WIDTH-1:0] min_reg;
    logic                   out_valid_reg;
    logic [2:0]             status_reg;
    logic [mhpq_pkg::InValueWidth-1:0] min_out_reg;
    logic [mhpq_pkg::CountOutWidth-1:0] cnt_out_reg;

    logic [CW-1:0] par, left, right, rd_pos, wr_pos;
    logic [CW:0]   left_w, right_w;
    logic [EW-1:0] wr_data;
    logic          wr_en;
    logic [VALUE_WIDTH-1:0] in_val;

    assign in_val  = VALUE_WIDTH'($signed(value));
    assign par     = pos_reg >> 1;
    // one extra bit so a child past the end never wraps
    assign left_w  = {pos_reg, 1'b0};
    assign right_w = {pos_reg, 1'b1};
    assign left    = left_w[CW-1:0];
    assign right   = right_w[CW-1:0];

    // heap positions are 1-based, memory index is position minus one
    always_comb
    begin
        unique case (cmd.rd_sel)
            mhpq_pkg::RdPos:   rd_pos = pos_reg;
            mhpq_pkg::RdPar:   rd_pos = par;
            mhpq_pkg::RdLeft:  rd_pos = left;
            mhpq_pkg::RdRight: rd_pos = right;
            mhpq_pkg::RdScan:  rd_pos = scan_reg;
            mhpq_pkg::RdLast:  rd_pos = cnt_reg;
            default:           rd_pos = pos_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_pos  = pos_reg;
        wr_data = a_reg;
        priority if (cmd.wr_new_last)
        begin
            wr_pos  = cnt_reg + CW'(1);
            wr_data = {val_reg, op_reg};
        end
        else if (cmd.wr_a_at_pos)
            wr_data = a_reg;
        else if (cmd.wr_b_at_pos)
            wr_data = b_reg;
        else if (cmd.wr_b_at_par)
        begin
            wr_pos  = par;
            wr_data = b_reg;
        end
        else if (cmd.wr_a_at_best)
            wr_pos = best_reg;
        else if (cmd.wr_val_at_pos)
            wr_data = {val_reg, a_reg[TW-1:0]};
        else
            wr_en = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(wr_pos - CW'(1))] <= wr_data;
        if (cmd.rd_en)
            rd_data <= mem[AW'(rd_pos - CW'(1))];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            val_reg  <= in_val;
            tag_reg  <= target_tag;
        end
        if (cmd.cap_a)
            a_reg <= rd_data;
        else if (cmd.a_from_in)
            a_reg <= {val_reg, a_reg[TW-1:0]};
        if (cmd.cap_b)
            b_reg <= rd_data;
        else if (cmd.b_from_c)
            b_reg <= c_reg;
        if (cmd.cap_c)
            c_reg <= rd_data;
        if (cmd.save_min)
            min_reg <= a_reg[EW-1:TW];
        if (cmd.set_best_left)
            best_reg <= left;
        else if (cmd.set_best_right)
            best_reg <= right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= TW'(1);
            cnt_reg       <= '0;
            pos_reg       <= CW'(1);
            scan_reg      <= CW'(1);
            out_valid_reg <= 1'b0;
            status_reg    <= mhpq_pkg::StDone;
            min_out_reg   <= '0;
            cnt_out_reg   <= '0;
        end
        else
        begin
            if (cmd.wr_new_last)
                pos_reg <= cnt_reg + CW'(1);
            else if (cmd.pos_to_par)
                pos_reg <= par;
            else if (cmd.pos_to_best)
                pos_reg <= best_reg;
            else if (cmd.pos_to_scan)
                pos_reg <= scan_reg;
            else if (cmd.load_item)
                pos_reg <= CW'(1);
            if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CW'(1);
            else if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - CW'(1);
            if (cmd.scan_init)
                scan_reg <= CW'(1);
            else if (cmd.scan_inc)
                scan_reg <= scan_reg + CW'(1);
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= cmd.out_status;
                op_reg        <= op_reg + TW'(1);
                cnt_out_reg   <= mhpq_pkg::CountOutWidth'(
                    cmd.cnt_dec ? cnt_reg - CW'(1) : cnt_reg);
                min_out_reg   <= (cmd.out_status == mhpq_pkg::StExtract)
                    ? mhpq_pkg::InValueWidth'(min_reg) : '0;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    function automatic logic lt(input logic [EW-1:0] x, input logic [EW-1:0] y);
        lt = $signed(x[EW-1:TW]) < $signed(y[EW-1:TW]);
    endfunction

    assign sts.mode        = mode_reg;
    assign sts.full        = cnt_reg >= CW'(CAPACITY);
    assign sts.empty       = cnt_reg == '0;
    assign sts.pos_is_root = pos_reg <= CW'(1);
    assign sts.a_lt_b      = lt(a_reg, b_reg);
    assign sts.b_lt_a      = lt(b_reg, a_reg);
    assign sts.c_lt_b      = lt(c_reg, b_reg);
    assign sts.left_ok     = left_w <= {1'b0, cnt_reg};
    assign sts.right_ok    = right_w <= {1'b0, cnt_reg};
    assign sts.scan_done   = scan_reg > cnt_reg;
    assign sts.tag_hit     = a_reg[TW-1:0] == tag_reg;
    assign sts.out_busy    = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign min_value   = min_out_reg;
    assign entry_count = cnt_out_reg;
endmodule

/* rtl/mhpq_ctrl.sv */
// ---------------------------------------------------------------------------
// mhpq_ctrl
// sequencer for push, extract-min and decrease-key
// ---------------------------------------------------------------------------
`include "min_heap_priority_queue_assert.svh"

module mhpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output mhpq_pkg::mhpq_cmd_t cmd,
    input  mhpq_pkg::mhpq_sts_t sts
);
    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_DISP   = 20'h00002,
        S_UP_RD  = 20'h00004,  // read sifting entry
        S_UP_W1  = 20'h00008,  // capture it, read parent
        S_UP_CMP = 20'h00010,  // capture parent
        S_UP_SW  = 20'h00020,
        S_UP_MV  = 20'h00040,
        S_EX_RD  = 20'h00080,  // capture root, read last
        S_EX_W1  = 20'h00100,
        S_EX_MV  = 20'h00200,
        S_DN_RD  = 20'h00400,  // read left child
        S_DN_W1  = 20'h00800,  // capture left, read right
        S_DN_W2  = 20'h01000,
        S_DN_SEL = 20'h02000,
        S_DN_SW  = 20'h04000,
        S_DN_MV  = 20'h08000,
        S_SC_RD  = 20'h10000,
        S_SC_CMP = 20'h20000,
        S_SC_CHK = 20'h40000,
        S_DONE   = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= mhpq_pkg::StDone;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.rd_sel = mhpq_pkg::RdPos;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    st_next       = mhpq_pkg::StDone;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.mode)
                    mhpq_pkg::ModePush:
                    begin
                        if (sts.full)
                        begin
                            st_next    = mhpq_pkg::StFull;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.wr_new_last = 1'b1;
                            cmd.cnt_inc     = 1'b1;
                            state_next      = S_UP_RD;
                        end
                    end
                    mhpq_pkg::ModeExtract:
                    begin
                        if (sts.empty)
                        begin
                            st_next    = mhpq_pkg::StEmpty;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = mhpq_pkg::RdPos;
                            st_next    = mhpq_pkg::StExtract;
                            state_next = S_EX_RD;
                        end
                    end
                    mhpq_pkg::ModeDecrease:
                    begin
                        cmd.scan_init = 1'b1;
                        st_next       = mhpq_pkg::StNotFound;
                        state_next    = S_SC_RD;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_UP_RD:
            begin
                if (sts.pos_is_root)
                    state_next = S_DONE;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = mhpq_pkg::RdPos;
                    state_next = S_UP_W1;
                end
            end
            S_UP_W1:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = mhpq_pkg::RdPar;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                cmd.cap_b  = 1'b1;
                state_next = S_UP_SW;
            end
            S_UP_SW:
            begin
                if (sts.a_lt_b)
                begin
                    // parent moves down, child goes up one level
                    cmd.wr_b_at_pos = 1'b1;
                    cmd.pos_to_par  = 1'b1;
                    state_next      = S_UP_MV;
                end
                else
                    state_next = S_DONE;
            end
            S_UP_MV:
            begin
                // place the rising entry, fetch the next parent
                cmd.wr_a_at_pos = 1'b1;
                if (sts.pos_is_root)
                    state_next = S_DONE;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = mhpq_pkg::RdPar;
                    state_next = S_UP_CMP;
                end
            end
            S_EX_RD:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = mhpq_pkg::RdLast;
                state_next = S_EX_W1;
            end
            S_EX_W1:
            begin
                cmd.save_min = 1'b1;
                cmd.cap_a    = 1'b1;
                state_next   = S_EX_MV;
            end
            S_EX_MV:
            begin
                // last entry goes to the root, and the count drops
                cmd.wr_a_at_pos = 1'b1;
                cmd.cnt_dec     = 1'b1;
                state_next      = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (!sts.left_ok)
                    state_next = S_DONE;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = mhpq_pkg::RdLeft;
                    state_next = S_DN_W1;
                end
            end
            S_DN_W1:
            begin
                cmd.cap_b         = 1'b1;
                cmd.set_best_left = 1'b1;
                cmd.rd_en         = sts.right_ok;
                cmd.rd_sel        = mhpq_pkg::RdRight;
                state_next        = S_DN_W2;
            end
            S_DN_W2:
            begin
                cmd.cap_c  = 1'b1;
                state_next = S_DN_SEL;
            end
            S_DN_SEL:
            begin
                // right child wins only when strictly smaller
                if (sts.right_ok && sts.c_lt_b)
                begin
                    cmd.b_from_c       = 1'b1;
                    cmd.set_best_right = 1'b1;
                end
                state_next = S_DN_SW;
            end
            S_DN_SW:
            begin
                if (sts.b_lt_a)
                begin
                    cmd.wr_b_at_pos = 1'b1;
                    state_next      = S_DN_MV;
                end
                else
                    state_next = S_DONE;
            end
            S_DN_MV:
            begin
                cmd.wr_a_at_best = 1'b1;
                cmd.pos_to_best  = 1'b1;
                state_next       = S_DN_RD;
            end
            S_SC_RD:
            begin
                if (sts.scan_done)
                    state_next = S_DONE;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = mhpq_pkg::RdScan;
                    state_next = S_SC_CMP;
                end
            end
            S_SC_CMP:
            begin
                cmd.cap_a  = 1'b1;
                state_next = S_SC_CHK;
            end
            S_SC_CHK:
            begin
                if (sts.tag_hit)
                begin
                    cmd.pos_to_scan = 1'b1;
                    cmd.a_from_in   = 1'b1;
                    st_next         = mhpq_pkg::StDone;
                    state_next      = S_UP_MV;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SC_RD;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    `MHPQ_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> state_reg == S_IDLE, "ready outside idle")
    `MHPQ_ASSERT(a_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `MHPQ_ASSERT(a_out_done, clk, rst_n, cmd.out_load |-> state_reg == S_DONE, "result outside done")
    `MHPQ_ASSERT(a_inc_dec, clk, rst_n, !(cmd.cnt_inc && cmd.cnt_dec), "count inc and dec")
endmodule

/* rtl/min_heap_priority_queue.sv */
// ---------------------------------------------------------------------------
// min_heap_priority_queue
// binary min-heap priority queue with push, extract-min and decrease-key
// ---------------------------------------------------------------------------
// One item is handled at a time. After the accepting cycle a push stores its
// entry at the end of the heap and then rises level by level; extract-min
// moves the last entry to the root and then sinks it level by level, both
// bounded by log2(CAPACITY) levels through the heap memory with its single
// read and single write port; decrease-key scans stored entries one by one,
// then rises level by level. Each item gives one result beat, registered; the
// result waits while the previous beat is not yet taken, and the next item is
// taken after that.
module min_heap_priority_queue #(
    parameter int CAPACITY    = mhpq_pkg::DefCapacity,
    parameter int VALUE_WIDTH = mhpq_pkg::DefValueWidth
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [1:0]                               mode,
    input  logic signed [mhpq_pkg::InValueWidth-1:0] value,
    input  logic [mhpq_pkg::TagWidth-1:0]            target_tag,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [2:0]                               status,
    output logic signed [mhpq_pkg::InValueWidth-1:0] min_value,
    output logic [mhpq_pkg::CountOutWidth-1:0]       entry_count
);
    mhpq_pkg::mhpq_cmd_t cmd;
    mhpq_pkg::mhpq_sts_t sts;

    mhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mhpq_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .mode        (mode),
        .value       (value),
        .target_tag  (target_tag),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .status      (status),
        .min_value   (min_value),
        .entry_count (entry_count)
    );
endmodule

/* verif/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// checks the min-heap queue against a behavioral heap kept in the bench
// ---------------------------------------------------------------------------
// A short table of directed operations comes first. Random pushes, extracts
// and decrease-keys follow, most of them aimed at tags still held in the
// heap. Every result beat is compared field by field with a queue of
// predicted results. It runs four phases of idles and stalls and pauses once
// until the queue drains. Mode 3 and the full-queue case are covered too.
module testbench;

    localparam int Cap      = mhpq_pkg::DefCapacity;
    localparam int MaxCycle = 4000000;
    localparam logic [1:0] ModeNop = 2'd3;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] val;
        logic [10:0] cnt;
    } heap_result_t;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] val;
        logic [23:0] tag;
        logic        typed;
        logic [2:0]  want_st;
        logic [31:0] want_val;
        logic [10:0] want_cnt;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          mode = mhpq_pkg::ModePush;
    logic signed [31:0]  value = '0;
    logic [23:0]         target_tag = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [2:0]          status;
    logic signed [31:0]  min_value;
    logic [10:0]         entry_count;

    // behavioral heap, one-based like the block
    logic signed [31:0]  hv [1:Cap];
    logic [23:0]         ht [1:Cap];
    int unsigned         held;
    logic [23:0]         op_num;

    heap_result_t        pending [$];
    int unsigned         mism;
    int unsigned         cycles;
    int                  send_idle;
    int                  recv_stall;

    min_heap_priority_queue u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .value      (value),
        .target_tag (target_tag),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .min_value  (min_value),
        .entry_count(entry_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MaxCycle)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic swap_entries(input int unsigned a, input int unsigned b);
        logic signed [31:0] v;
        logic [23:0]        t;
        begin
            v = hv[a]; t = ht[a];
            hv[a] = hv[b]; ht[a] = ht[b];
            hv[b] = v; ht[b] = t;
        end
    endtask

    task automatic bubble_up(input int unsigned p);
        begin
            while (p > 1 && hv[p] < hv[p / 2])
            begin
                swap_entries(p, p / 2);
                p = p / 2;
            end
        end
    endtask

    task automatic heap_apply(input logic [1:0] op, input logic signed [31:0] v,
                              input logic [23:0] tg, output heap_result_t r);
        int unsigned p, b, l;
        bit          stop;
        begin
            r = '0;
            case (op)
                mhpq_pkg::ModePush:
                    if (held >= Cap) r.st = mhpq_pkg::StFull;
                    else
                    begin
                        held++;
                        hv[held] = v;
                        ht[held] = op_num;
                        bubble_up(held);
                    end
                mhpq_pkg::ModeExtract:
                    if (held == 0) r.st = mhpq_pkg::StEmpty;
                    else
                    begin
                        r.st = mhpq_pkg::StExtract;
                        r.val = hv[1];
                        swap_entries(1, held);
                        held--;
                        p = 1;
                        stop = 0;
                        while (!stop && p <= held)
                        begin
                            b = p;
                            l = 2 * p;
                            if (l <= held && hv[l] < hv[b]) b = l;
                            if (l + 1 <= held && hv[l + 1] < hv[b]) b = l + 1;
                            if (b == p) stop = 1;
                            else
                            begin
                                swap_entries(p, b);
                                p = b;
                            end
                        end
                    end
                mhpq_pkg::ModeDecrease:
                begin
                    r.st = mhpq_pkg::StNotFound;
                    for (p = 1; p <= held && r.st == mhpq_pkg::StNotFound; p++)
                        if (ht[p] == tg)
                        begin
                            hv[p] = v;
                            bubble_up(p);
                            r.st = mhpq_pkg::StDone;
                        end
                end
                default: r.st = mhpq_pkg::StDone;
            endcase
            op_num = op_num + 1'b1;
            r.cnt = held[10:0];
        end
    endtask

    // sends one beat; queues the prediction, typed rows override it
    task automatic send_op(input stim_row_t row);
        heap_result_t r;
        begin
            if (send_idle > 0 && $urandom_range(99) < send_idle)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < send_idle)
                    @(posedge clk);
            end
            heap_apply(row.op, row.val, row.tag, r);
            if (row.typed)
                r = '{row.want_st, row.want_val, row.want_cnt};
            in_valid   <= 1'b1;
            mode       <= row.op;
            value      <= row.val;
            target_tag <= row.tag;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            pending.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end

    always @(posedge clk)
    begin
        heap_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending.size() == 0)
            begin
                mism++;
                if (mism <= 10) $display("unexpected beat st=%0d", status);
            end
            else
            begin
                e = pending.pop_front();
                if (e.st !== status || e.val !== min_value || e.cnt !== entry_count)
                begin
                    mism++;
                    if (mism <= 10)
                        $display("mismatch exp st=%0d val=%0d cnt=%0d got %0d %0d %0d",
                                 e.st, $signed(e.val), e.cnt, status, min_value,
                                 entry_count);
                end
            end
        end
    end

    function automatic stim_row_t mk(input logic [1:0] op, input logic [31:0] v,
                                     input logic [23:0] tg);
        mk = '{op, v, tg, 1'b0, 3'd0, 32'd0, 11'd0};
    endfunction

    function automatic stim_row_t mkt(input logic [1:0] op, input logic [31:0] v,
                                      input logic [23:0] tg, input logic [2:0] s,
                                      input logic [31:0] mv, input logic [10:0] c);
        mkt = '{op, v, tg, 1'b1, s, mv, c};
    endfunction

    function automatic stim_row_t rand_op();
        int unsigned k;
        logic [31:0] v;
        begin
            k = $urandom_range(99);
            case ($urandom_range(3))
                0: v = 32'h8000_0000 | $urandom_range(3);
                1: v = 32'h7fff_fffc | $urandom_range(3);
                2: v = $urandom_range(40);
                default: v = $urandom;
            endcase
            if (k < 45) rand_op = mk(mhpq_pkg::ModePush, v, 24'($urandom));
            else if (k < 80)
                rand_op = mk(mhpq_pkg::ModeExtract, $urandom, 24'($urandom));
            else if (k < 95 && held > 0)
                rand_op = mk(mhpq_pkg::ModeDecrease, v, ht[$urandom_range(held - 1) + 1]);
            else if (k < 98)
                rand_op = mk(mhpq_pkg::ModeDecrease, v, 24'($urandom));
            else rand_op = mk(ModeNop, $urandom, 24'($urandom));
        end
    endfunction

    task automatic drain();
        int n;
        begin
            n = 0;
            in_valid <= 1'b0;
            while (pending.size() != 0) @(posedge clk);
            while (n < 64)
            begin
                @(posedge clk);
                n++;
            end
        end
    endtask

    initial
    begin
        stim_row_t dir [$];
        stim_row_t row;
        int        ph;
        int        i;
        held = 0;
        op_num = 24'd1;
        mism = 0;
        cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tags follow operation numbers: op 1 is the first row, so the first push has tag 3
        dir.push_back(mkt(mhpq_pkg::ModeExtract, 32'h0, 24'h0, mhpq_pkg::StEmpty,
                          32'h0, 11'd0));
        dir.push_back(mkt(mhpq_pkg::ModeDecrease, 32'h5, 24'h1, mhpq_pkg::StNotFound,
                          32'h0, 11'd0));
        dir.push_back(mkt(mhpq_pkg::ModePush, 32'h7fff_ffff, 24'hff_ffff,
                          mhpq_pkg::StDone, 32'h0, 11'd1));
        dir.push_back(mkt(mhpq_pkg::ModePush, 32'h8000_0000, 24'h0, mhpq_pkg::StDone,
                          32'h0, 11'd2));
        dir.push_back(mkt(mhpq_pkg::ModePush, 32'h0, 24'h0, mhpq_pkg::StDone,
                          32'h0, 11'd3));
        dir.push_back(mkt(mhpq_pkg::ModePush, 32'h0, 24'h0, mhpq_pkg::StDone,
                          32'h0, 11'd4));
        dir.push_back(mkt(ModeNop, 32'hffff_ffff, 24'hff_ffff, mhpq_pkg::StDone,
                          32'h0, 11'd4));
        dir.push_back(mkt(mhpq_pkg::ModeExtract, 32'h0, 24'h0, mhpq_pkg::StExtract,
                          32'h8000_0000, 11'd3));
        dir.push_back(mk(mhpq_pkg::ModeDecrease, 32'h8000_0000, 24'd3));
        dir.push_back(mk(mhpq_pkg::ModeDecrease, 32'h7fff_ffff, 24'd5));
        dir.push_back(mk(mhpq_pkg::ModePush, 32'hffff_ffff, 24'h0));
        dir.push_back(mk(mhpq_pkg::ModePush, 32'h1, 24'h0));
        dir.push_back(mk(mhpq_pkg::ModeExtract, 32'h0, 24'h0));
        dir.push_back(mk(mhpq_pkg::ModeExtract, 32'h0, 24'h0));
        dir.push_back(mk(mhpq_pkg::ModeExtract, 32'h0, 24'h0));
        dir.push_back(mk(mhpq_pkg::ModeExtract, 32'h0, 24'h0));
        dir.push_back(mk(mhpq_pkg::ModeExtract, 32'h0, 24'h0));
        dir.push_back(mkt(mhpq_pkg::ModeExtract, 32'h0, 24'h0, mhpq_pkg::StEmpty,
                          32'h0, 11'd0));
        foreach (dir[j]) send_op(dir[j]);

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 79 : 23) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 79 : 23) : 0;
            for (i = 0; i < 100; i++)
            begin
                send_op(rand_op());
                if (ph == 0 && i == 50) drain();
            end
        end

        // fill to capacity, overflow, decrease a key, then take some back out
        send_idle = 0;
        recv_stall = 10;
        while (held < Cap) send_op(mk(mhpq_pkg::ModePush, $urandom, 24'h0));
        send_op(mk(mhpq_pkg::ModePush, 32'h5, 24'h0));
        send_op(mk(mhpq_pkg::ModeDecrease, 32'h8000_0001, ht[Cap]));
        for (i = 0; i < 60; i++) send_op(mk(mhpq_pkg::ModeExtract, 32'h0, 24'h0));

        drain();
        if (mism == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
